@@ hdl/lsb_message_extractor_top_defines.svh @@
// Assertion helpers shared by the extractor modules.
// Every check is sampled on the rising edge of clock and is ignored while reset is high.
`ifndef LSB_MESSAGE_EXTRACTOR_TOP_DEFINES_SVH
`define LSB_MESSAGE_EXTRACTOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LME_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lme_pkg.sv @@
`timescale 1ns / 1ps

package lme_pkg;

   // Number of payload bytes that make up the big-endian message length.
   localparam logic [2:0] LENGTH_BYTES = 3'd4;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_DATA   = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_LENGTH = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_SHORT  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] carrier_byte;
      logic       carrier_last;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [31:0] result_value;
      logic        message_last;
   } rsp_type;

   // Results produced by one request, handed from the decoder to the queue.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

@@ hdl/lme_decode.sv @@
`timescale 1ns / 1ps
`include "lsb_message_extractor_top_defines.svh"

module lme_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_write_data,
   input  logic              item_valid,
   input  lme_pkg::req_type  item,
   input  logic [1:0]        queue_count,
   output logic              consume,
   output lme_pkg::push_type push
);

   lme_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  bpc_log2_ff;
   logic [7:0]  bit_gather_ff, bit_gather_in;
   logic [3:0]  fields_taken_ff, fields_taken_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [31:0] length_gather_ff, length_gather_in;
   logic [31:0] remaining_count_ff, remaining_count_in;

   lme_pkg::rsp_type main_rsp, short_rsp;
   logic        main_hit, short_hit;
   logic [1:0]  result_count;

   always_comb begin
      logic [7:0]  gathered;
      logic [3:0]  need;
      logic [3:0]  taken_inc;
      logic [2:0]  header_inc;
      logic [31:0] length_new;
      logic [31:0] remaining_dec;
      lme_pkg::phase_type phase_mid;

      phase_in           = phase_ff;
      bit_gather_in      = bit_gather_ff;
      fields_taken_in    = fields_taken_ff;
      header_count_in    = header_count_ff;
      length_gather_in   = length_gather_ff;
      remaining_count_in = remaining_count_ff;
      main_hit           = 1'b0;
      main_rsp           = '{lme_pkg::KIND_LENGTH, 32'd0, 1'b0};
      short_rsp          = '{lme_pkg::KIND_SHORT, 32'd0, 1'b0};

      unique case (bpc_log2_ff)
         2'd0: begin
            gathered = {bit_gather_ff[6:0], item.carrier_byte[0]};
            need     = 4'd8;
         end
         2'd1: begin
            gathered = {bit_gather_ff[5:0], item.carrier_byte[1:0]};
            need     = 4'd4;
         end
         2'd2: begin
            gathered = {bit_gather_ff[3:0], item.carrier_byte[3:0]};
            need     = 4'd2;
         end
         default: begin
            gathered = item.carrier_byte;
            need     = 4'd1;
         end
      endcase

      taken_inc     = fields_taken_ff + 4'd1;
      header_inc    = header_count_ff + 3'd1;
      length_new    = {length_gather_ff[23:0], gathered};
      remaining_dec = remaining_count_ff - 32'd1;

      if (phase_ff != lme_pkg::PHASE_DONE) begin
         bit_gather_in   = gathered;
         fields_taken_in = taken_inc;
         if (taken_inc >= need) begin
            bit_gather_in   = 8'd0;
            fields_taken_in = 4'd0;
            if (phase_ff == lme_pkg::PHASE_HEADER) begin
               length_gather_in = length_new;
               header_count_in  = header_inc;
               if (header_inc >= lme_pkg::LENGTH_BYTES) begin
                  main_hit           = 1'b1;
                  main_rsp           = '{lme_pkg::KIND_LENGTH, length_new,
                                         (length_new == 32'd0)};
                  remaining_count_in = length_new;
                  phase_in           = (length_new == 32'd0) ? lme_pkg::PHASE_DONE
                                                             : lme_pkg::PHASE_DATA;
                  header_count_in    = 3'd0;
                  length_gather_in   = 32'd0;
               end
            end else begin
               remaining_count_in = remaining_dec;
               main_hit           = 1'b1;
               main_rsp           = '{lme_pkg::KIND_DATA, {24'd0, gathered},
                                      (remaining_dec == 32'd0)};
               if (remaining_dec == 32'd0) begin
                  phase_in = lme_pkg::PHASE_DONE;
               end
            end
         end
      end

      phase_mid = phase_in;
      short_hit = item.carrier_last && (phase_mid != lme_pkg::PHASE_DONE);

      // The end of the image always returns the extractor to a fresh header.
      if (item.carrier_last) begin
         phase_in           = lme_pkg::PHASE_HEADER;
         bit_gather_in      = 8'd0;
         fields_taken_in    = 4'd0;
         header_count_in    = 3'd0;
         length_gather_in   = 32'd0;
         remaining_count_in = 32'd0;
      end
   end

   assign result_count = {1'b0, main_hit} + {1'b0, short_hit};
   assign consume      = item_valid && (result_count <= (2'd2 - queue_count));

   always_comb begin
      push.count  = consume ? result_count : 2'd0;
      push.first  = main_hit ? main_rsp : short_rsp;
      push.second = short_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_log2_ff        <= 2'd0;
         phase_ff           <= lme_pkg::PHASE_HEADER;
         bit_gather_ff      <= 8'd0;
         fields_taken_ff    <= 4'd0;
         header_count_ff    <= 3'd0;
         length_gather_ff   <= 32'd0;
         remaining_count_ff <= 32'd0;
      end else begin
         if (csr_write_enable) begin
            bpc_log2_ff <= csr_write_data;
         end
         if (consume) begin
            phase_ff           <= phase_in;
            bit_gather_ff      <= bit_gather_in;
            fields_taken_ff    <= fields_taken_in;
            header_count_ff    <= header_count_in;
            length_gather_ff   <= length_gather_in;
            remaining_count_ff <= remaining_count_in;
         end
      end
   end

   `LME_ASSERT_NEXT(a_last_clears, consume && item.carrier_last,
      phase_ff == lme_pkg::PHASE_HEADER && fields_taken_ff == 4'd0 && header_count_ff == 3'd0,
      "end of image did not return to a fresh header")
   `LME_ASSERT_SAME(a_short_only_on_last,
      push.count != 2'd0 && push.first.result_kind == lme_pkg::KIND_SHORT,
      item.carrier_last, "short-image error raised without the last carrier byte")
   `LME_ASSERT_SAME(a_done_is_quiet,
      consume && phase_ff == lme_pkg::PHASE_DONE && !item.carrier_last,
      push.count == 2'd0, "result produced after the message was complete")

endmodule

@@ hdl/lme_rsp_queue.sv @@
`timescale 1ns / 1ps
`include "lsb_message_extractor_top_defines.svh"

module lme_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  lme_pkg::push_type push,
   output logic [1:0]        queue_count,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lme_pkg::rsp_type  rsp_payload
);

   // Entry zero is always the head of the queue.
   lme_pkg::rsp_type head_ff, head_in;
   lme_pkg::rsp_type tail_ff, tail_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      logic       pop;
      logic [1:0] kept;

      pop     = (count_ff != 2'd0) && !rsp_stall;
      head_in = head_ff;
      tail_in = tail_ff;
      kept    = count_ff;
      if (pop) begin
         head_in = tail_ff;
         kept    = count_ff - 2'd1;
      end
      if (push.count != 2'd0) begin
         if (kept == 2'd0) begin
            head_in = push.first;
            tail_in = push.second;
         end else begin
            tail_in = push.first;
         end
      end
      count_in = kept + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign queue_count = count_ff;
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = head_ff;

   `LME_ASSERT_SAME(a_no_overflow, push.count != 2'd0,
      ({1'b0, push.count} + {1'b0, count_ff}) <= 3'd2, "result queue overflow")

endmodule

@@ hdl/lsb_message_extractor_top.sv @@
`timescale 1ns / 1ps
`include "lsb_message_extractor_top_defines.svh"

// LSB message extractor. Each request carries one carrier byte; the extractor keeps its
// low 1, 2, 4 or 8 bits (set by csr_write_data as a log2 value) and packs them most
// significant first into payload bytes. The first four payload bytes are a big-endian
// message length, reported once, followed by that many data bytes, the final one marked
// with message_last. A carrier byte marked last ends the image: if the message is still
// incomplete at that point an error result follows any result that byte completed, and
// the extractor always returns to looking for a new header. The block accepts one
// request per clock unless req_stall holds it: a request is registered on entry,
// decoded in the next cycle, and its results land in a two-entry output queue. Results
// leave at one per clock while rsp_stall is low. The first result of a request passes
// through the input register and the output queue before it is offered. The register
// must be written only while no request is in flight; the block itself does not enforce
// this.
module lsb_message_extractor_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  lme_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lme_pkg::rsp_type rsp_payload
);

   // Input register: holds the request that the decoder works on this cycle.
   logic             in_valid_ff, in_valid_in;
   lme_pkg::req_type in_data_ff;

   logic              consume;
   logic [1:0]        queue_count;
   lme_pkg::push_type push;

   // The held request stays put until the decoder can place all of its results in the
   // output queue; only then is room made for the next one.
   assign req_stall   = in_valid_ff && !consume;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
   end

   lme_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (in_valid_ff),
      .item             (in_data_ff),
      .queue_count      (queue_count),
      .consume          (consume),
      .push             (push)
   );

   lme_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_count (queue_count),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A stalled request must remain held in the input register.
   `LME_ASSERT_NEXT(a_stall_holds, req_stall, in_valid_ff, "held request was lost")

endmodule
